### rtl/tdp_pkg.sv
`default_nettype none

package tdp_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned MAG_BITS   = VALUE_BITS - 1;
  localparam int unsigned CNT_BITS   = $clog2(MAG_BITS);

  typedef logic [MAG_BITS-1:0] mag_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

### rtl/tdp_serial_div.sv
`default_nettype none

module tdp_serial_div (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire tdp_pkg::mag_t        dividend_i,
  input  wire tdp_pkg::mag_t        divisor_i,
  output tdp_pkg::div_status_t      status_o,
  output tdp_pkg::mag_t             quotient_o,
  output tdp_pkg::mag_t             remainder_o
);

  logic                busy_q;
  logic                done_q;
  tdp_pkg::cnt_t       cnt_q;
  tdp_pkg::mag_t       rem_q;
  tdp_pkg::mag_t       quo_q;
  tdp_pkg::mag_t       dvs_q;
  logic [tdp_pkg::MAG_BITS:0] trial;

  assign trial = {rem_q, quo_q[tdp_pkg::MAG_BITS-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + tdp_pkg::cnt_t'(1);
        if (cnt_q == tdp_pkg::cnt_t'(tdp_pkg::MAG_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle; the dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[tdp_pkg::MAG_BITS]) begin
        rem_q <= trial[tdp_pkg::MAG_BITS-1:0];
        quo_q <= {quo_q[tdp_pkg::MAG_BITS-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[tdp_pkg::MAG_BITS-2:0], quo_q[tdp_pkg::MAG_BITS-1]};
        quo_q <= {quo_q[tdp_pkg::MAG_BITS-2:0], 1'b0};
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

endmodule

`default_nettype wire

### rtl/trial_division_prime_test_unit.sv
`default_nettype none

// Trial-division primality test. Each input beat carries one signed candidate and
// produces one output beat whose flag is 1 when the candidate is prime. Negative
// values, zero and one are answered directly, without the divider. Otherwise divisors
// 2, 3, 4 and so on go through a bit-serial restoring divider, each with a load, one
// shift-subtract step per magnitude bit and a decision, and the search stops at the
// first exact divisor or once the divisor exceeds the quotient. One candidate is
// worked on at a time; a finished result sits in the output register while the next
// candidate is accepted.
module trial_division_prime_test_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [tdp_pkg::VALUE_BITS-1:0] candidate_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     prime_flag_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_e;

  state_e               st_q;
  logic                 start_q;
  logic                 res_q;
  logic                 out_valid_q;
  logic                 prime_flag_q;
  tdp_pkg::mag_t        v_q;
  tdp_pkg::mag_t        d_q;
  tdp_pkg::div_status_t div_stat;
  tdp_pkg::mag_t        quo;
  tdp_pkg::mag_t        rem;
  logic                 out_take;

  tdp_serial_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .dividend_i  (v_q),
    .divisor_i   (d_q),
    .status_o    (div_stat),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      start_q      <= 1'b0;
      res_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      prime_flag_q <= 1'b0;
      v_q          <= '0;
      d_q          <= '0;
    end else begin
      start_q <= 1'b0;
      if (out_take && (st_q != S_HOLD)) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (candidate_i[tdp_pkg::VALUE_BITS-1] ||
                (candidate_i[tdp_pkg::MAG_BITS-1:0] < tdp_pkg::mag_t'(2))) begin
              res_q <= 1'b0;
              st_q  <= S_HOLD;
            end else begin
              v_q     <= candidate_i[tdp_pkg::MAG_BITS-1:0];
              d_q     <= tdp_pkg::mag_t'(2);
              start_q <= 1'b1;
              st_q    <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (d_q > quo) begin
              res_q <= 1'b1;
              st_q  <= S_HOLD;
            end else if (rem == '0) begin
              res_q <= 1'b0;
              st_q  <= S_HOLD;
            end else begin
              d_q     <= d_q + tdp_pkg::mag_t'(1);
              start_q <= 1'b1;
            end
          end
        end
        S_HOLD: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            prime_flag_q <= res_q;
            st_q         <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (st_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign prime_flag_o = prime_flag_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> div_stat.busy)
    else $error("divider did not start");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> (!div_stat.busy && !start_q))
    else $error("divider active while idle");

  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == S_HOLD))
    else $error("result beat without a finished test");

  a_divisor_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (d_q >= tdp_pkg::mag_t'(2)))
    else $error("divisor below two");

endmodule

`default_nettype wire

### dv/trial_division_prime_test_checker.sv
`default_nettype none

module trial_division_prime_test_checker (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  input  wire logic                                  in_stall_i,
  input  wire logic signed [tdp_pkg::VALUE_BITS-1:0] candidate_i,
  input  wire logic                                  out_valid_i,
  input  wire logic                                  out_stall_i,
  input  wire logic                                  prime_flag_i,
  output int                                         fail_count_o,
  output int                                         pending_o
);

  typedef struct {
    logic signed [tdp_pkg::VALUE_BITS-1:0] candidate;
    logic                                  prime;
  } verdict_t;

  verdict_t verdict_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic expect_prime(input logic signed [tdp_pkg::VALUE_BITS-1:0] cand);
    longint unsigned n;
    longint unsigned d;
    if (cand < 2) begin
      return 1'b0;
    end
    n = longint'(cand);
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        exp_v.candidate = candidate_i;
        exp_v.prime     = expect_prime(candidate_i);
        verdict_q       = {verdict_q, exp_v};
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result beat with prime_flag=%0b but none expected",
                                    prime_flag_i));
        end else begin
          exp_v = verdict_q.pop_front();
          if (prime_flag_i !== exp_v.prime) begin
            report_mismatch($sformatf("candidate %0d: prime_flag=%0b, expected %0b",
                                      exp_v.candidate, prime_flag_i, exp_v.prime));
          end
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

`default_nettype wire

### dv/trial_division_prime_test_unit_tb.sv
`default_nettype none

module trial_division_prime_test_unit_tb;

  localparam int unsigned VB        = tdp_pkg::VALUE_BITS;
  localparam int          N_RANDOM  = 100;
  localparam longint      RUN_LIMIT = 64'd200_000_000;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic signed [VB-1:0] candidate_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic                 prime_flag_o;

  int fail_count;
  int pending_count;
  int burst_left;
  int stall_mode;
  int stall_cycles;

  always #4 clk_i = ~clk_i;

  trial_division_prime_test_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .candidate_i (candidate_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .prime_flag_o(prime_flag_o)
  );

  trial_division_prime_test_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .candidate_i (candidate_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .prime_flag_i(prime_flag_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  // The receiver switches between no stall, random stall and heavy stall.
  always @(posedge clk_i) begin
    if (stall_cycles == 0) begin
      stall_mode   <= $urandom_range(0, 2);
      stall_cycles <= $urandom_range(16, 96);
    end else begin
      stall_cycles <= stall_cycles - 1;
    end
    case (stall_mode)
      1: begin
        out_stall_i <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 7) != 0);
      end
      default: begin
        out_stall_i <= 1'b0;
      end
    endcase
  end

  initial begin
    stall_mode   = 0;
    stall_cycles = 0;
  end

  task automatic send_candidate(input logic signed [VB-1:0] value);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    in_valid_i  <= 1'b1;
    candidate_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
  endtask

  function automatic logic signed [VB-1:0] random_candidate();
    int unsigned pick;
    int unsigned raw;
    int unsigned factor;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      return $urandom_range(0, 4095);
    end else if (pick < 60) begin
      return $urandom_range(4096, 1 << 20);
    end else if (pick < 75) begin
      raw = $urandom();
      return {1'b1, raw[VB-2:0]};
    end else if (pick < 92) begin
      // Large positives with a small factor keep the divisor search short.
      raw    = $urandom_range(1 << 24, 32'h7fff_ffff);
      factor = $urandom_range(0, 3);
      factor = (factor == 0) ? 2 : (factor == 1) ? 3 : (factor == 2) ? 5 : 7;
      return (raw / factor) * factor;
    end else begin
      return $signed($urandom_range(0, 64)) - 32;
    end
  endfunction

  initial begin
    logic signed [VB-1:0] directed[$];
    directed = '{32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd4,
                 32'sd5, 32'sd9, 32'sd25, 32'sd49, 32'sd97, 32'sd121, 32'sd63001,
                 32'sd65521, 32'sd65536, 32'sd65537, 32'sd1048573, 32'sh7fff_fffe,
                 32'sh7fff_fffd, 32'sh7fff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa};
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_candidate(directed[i]);
    end
    repeat (N_RANDOM) begin
      send_candidate(random_candidate());
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d results outstanding.", pending_count);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/tdp_pkg.sv
rtl/tdp_serial_div.sv
rtl/trial_division_prime_test_unit.sv
dv/trial_division_prime_test_checker.sv
dv/trial_division_prime_test_unit_tb.sv
